// File: hdl/kgm_pkg.sv
// Shared types, codes and key mapping tables for the key and serial gamepad merger.
package kgm_pkg;

    localparam int BUTTON_COUNT   = 8;
    localparam int BTN_IDX_W      = $clog2(BUTTON_COUNT);
    localparam int ESCAPE_TIMEOUT = 3;
    localparam int AGE_W          = 3;

    // Item kinds carried on s_axis_tuser.
    localparam logic [1:0] OP_SERIAL   = 2'd0;
    localparam logic [1:0] OP_KEY      = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Button positions in the result word.
    localparam logic [BTN_IDX_W-1:0] BT_A      = 3'd0;
    localparam logic [BTN_IDX_W-1:0] BT_B      = 3'd1;
    localparam logic [BTN_IDX_W-1:0] BT_SELECT = 3'd2;
    localparam logic [BTN_IDX_W-1:0] BT_START  = 3'd3;
    localparam logic [BTN_IDX_W-1:0] BT_UP     = 3'd4;
    localparam logic [BTN_IDX_W-1:0] BT_DOWN   = 3'd5;
    localparam logic [BTN_IDX_W-1:0] BT_LEFT   = 3'd6;
    localparam logic [BTN_IDX_W-1:0] BT_RIGHT  = 3'd7;

    // Terminal bytes with special meaning.
    localparam logic [7:0] CHR_ESC     = 8'h1b;
    localparam logic [7:0] CHR_CTRL_C  = 8'h03;
    localparam logic [7:0] CHR_BRACKET = 8'h5b;
    localparam logic [7:0] CHR_Q_LO    = 8'h71;
    localparam logic [7:0] CHR_Q_UP    = 8'h51;
    localparam logic [7:0] CHR_ARROW_U = 8'h41;
    localparam logic [7:0] CHR_ARROW_D = 8'h42;
    localparam logic [7:0] CHR_ARROW_R = 8'h43;
    localparam logic [7:0] CHR_ARROW_L = 8'h44;

    // Input event codes.
    localparam logic [4:0] EV_KEY       = 5'd1;
    localparam logic [9:0] KEY_ESC      = 10'd1;
    localparam logic [9:0] KEY_Q        = 10'd16;
    localparam logic [1:0] KV_RELEASE   = 2'd0;
    localparam logic [1:0] KV_PRESS     = 2'd1;
    localparam logic [1:0] KV_REPEAT    = 2'd2;
    localparam logic [1:0] KV_UNDEFINED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_HOLD_LEN    = 2'd0;
    localparam logic [1:0] REG_SERIAL_EN   = 2'd1;
    localparam logic [1:0] REG_KEYBOARD_EN = 2'd2;

    typedef enum logic [1:0] {
        ESC_PLAIN   = 2'd0,
        ESC_GOT_ESC = 2'd1,
        ESC_GOT_CSI = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] serial_byte;
        logic [4:0] event_type;
        logic [9:0] key_code;
        logic [1:0] key_value;
    } item_t;

    typedef struct packed {
        logic [7:0] hold_len;
        logic       serial_enable;
        logic       keyboard_enable;
    } cfg_t;

    typedef struct packed {
        logic                 hit;
        logic [BTN_IDX_W-1:0] idx;
    } btn_map_t;

    function automatic btn_map_t key_to_button(input logic [9:0] code);
        btn_map_t m;
        m.hit = 1'b1;
        m.idx = BT_A;
        case (code)
            10'd103, 10'd17: m.idx = BT_UP;
            10'd108, 10'd31: m.idx = BT_DOWN;
            10'd105, 10'd30: m.idx = BT_LEFT;
            10'd106, 10'd32: m.idx = BT_RIGHT;
            10'd37,  10'd45: m.idx = BT_A;
            10'd36,  10'd44: m.idx = BT_B;
            10'd28:          m.idx = BT_START;
            10'd57:          m.idx = BT_SELECT;
            default:         m.hit = 1'b0;
        endcase
        return m;
    endfunction

    function automatic btn_map_t byte_to_button(input logic [7:0] c);
        btn_map_t m;
        m.hit = 1'b1;
        m.idx = BT_A;
        case (c)
            8'h77, 8'h57:               m.idx = BT_UP;     // w W
            8'h73, 8'h53:               m.idx = BT_DOWN;   // s S
            8'h61, 8'h41:               m.idx = BT_LEFT;   // a A
            8'h64, 8'h44:               m.idx = BT_RIGHT;  // d D
            8'h6b, 8'h4b, 8'h78, 8'h58: m.idx = BT_A;      // k K x X
            8'h6a, 8'h4a, 8'h7a, 8'h5a: m.idx = BT_B;      // j J z Z
            8'h0d, 8'h0a:               m.idx = BT_START;  // CR LF
            8'h20:                      m.idx = BT_SELECT; // space
            default:                    m.hit = 1'b0;
        endcase
        return m;
    endfunction

endpackage

// File: hdl/kgm_in_stage.sv
// Input register that captures one transaction from the slave stream port.
module kgm_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [31:0]    s_axis_tdata,
    input  logic [1:0]     s_axis_tuser,
    output logic           item_valid,
    output kgm_pkg::item_t item,
    input  logic           item_take
);
    import kgm_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // The register can load whenever it is empty or its content leaves this cycle.
    // Nothing is taken while reset is held.
    assign s_axis_tready = aresetn && (!valid_reg || item_take);
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            item_reg.op          <= s_axis_tuser;
            item_reg.serial_byte <= s_axis_tdata[7:0];
            item_reg.event_type  <= s_axis_tdata[12:8];
            item_reg.key_code    <= s_axis_tdata[22:13];
            item_reg.key_value   <= s_axis_tdata[24:23];
        end
    end

endmodule

// File: hdl/kgm_core.sv
// Button state, escape decoder and result register of the gamepad merger.
module kgm_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  kgm_pkg::cfg_t  cfg,
    input  logic           item_valid,
    input  kgm_pkg::item_t item,
    output logic           item_take,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [15:0]    m_axis_tdata
);
    import kgm_pkg::*;

    logic [7:0]              hold_count_reg [BUTTON_COUNT];
    logic [7:0]              hold_count_next [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] key_down_reg, key_down_next;
    logic [BUTTON_COUNT-1:0] key_tap_reg, key_tap_next;
    logic                    quit_reg, quit_next;
    esc_phase_t              esc_phase_reg, esc_phase_next;
    logic [AGE_W-1:0]        esc_age_reg, esc_age_next;
    logic                    m_valid_reg;
    logic [8:0]              m_data_reg;
    logic [8:0]              result;
    logic                    is_tick;
    logic                    out_free;
    btn_map_t                byte_map;
    btn_map_t                key_map;
    logic [AGE_W:0]          age_inc;

    assign is_tick   = (item.op == OP_TICK);
    assign out_free  = !m_valid_reg || m_axis_tready;
    // A tick needs room in the result register; every other item always goes.
    assign item_take = item_valid && (!is_tick || out_free);

    assign byte_map = byte_to_button(item.serial_byte);
    assign key_map  = key_to_button(item.key_code);
    assign age_inc  = {1'b0, esc_age_reg} + {{AGE_W{1'b0}}, 1'b1};

    always_comb begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            result[i] = key_down_reg[i] || key_tap_reg[i] || (hold_count_reg[i] != 8'd0);
        end
        result[BUTTON_COUNT] = quit_reg;
    end

    always_comb begin
        hold_count_next = hold_count_reg;
        key_down_next   = key_down_reg;
        key_tap_next    = key_tap_reg;
        quit_next       = quit_reg;
        esc_phase_next  = esc_phase_reg;
        esc_age_next    = esc_age_reg;
        if (item_take) begin
            case (item.op)
                OP_SERIAL: begin
                    if (cfg.serial_enable) begin
                        unique case (esc_phase_reg)
                            ESC_GOT_ESC: begin
                                esc_phase_next = (item.serial_byte == CHR_BRACKET) ?
                                                 ESC_GOT_CSI : ESC_PLAIN;
                            end
                            ESC_GOT_CSI: begin
                                esc_phase_next = ESC_PLAIN;
                                if (item.serial_byte == CHR_ARROW_U) begin
                                    hold_count_next[BT_UP] = cfg.hold_len;
                                end else if (item.serial_byte == CHR_ARROW_D) begin
                                    hold_count_next[BT_DOWN] = cfg.hold_len;
                                end else if (item.serial_byte == CHR_ARROW_R) begin
                                    hold_count_next[BT_RIGHT] = cfg.hold_len;
                                end else if (item.serial_byte == CHR_ARROW_L) begin
                                    hold_count_next[BT_LEFT] = cfg.hold_len;
                                end
                            end
                            ESC_PLAIN: begin
                                if (item.serial_byte == CHR_ESC) begin
                                    esc_phase_next = ESC_GOT_ESC;
                                    esc_age_next   = '0;
                                end else if (item.serial_byte == CHR_Q_LO ||
                                             item.serial_byte == CHR_Q_UP ||
                                             item.serial_byte == CHR_CTRL_C) begin
                                    quit_next = 1'b1;
                                end else if (byte_map.hit) begin
                                    hold_count_next[byte_map.idx] = cfg.hold_len;
                                end
                            end
                            default: begin
                                esc_phase_next = ESC_PLAIN;
                            end
                        endcase
                    end
                end
                OP_KEY: begin
                    if (cfg.keyboard_enable && item.event_type == EV_KEY) begin
                        if ((item.key_code == KEY_Q || item.key_code == KEY_ESC) &&
                            item.key_value == KV_PRESS) begin
                            quit_next = 1'b1;
                        end else if (key_map.hit) begin
                            key_down_next[key_map.idx] = (item.key_value != KV_RELEASE);
                            if (item.key_value != KV_RELEASE) begin
                                key_tap_next[key_map.idx] = 1'b1;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    key_tap_next = '0;
                    for (int i = 0; i < BUTTON_COUNT; i++) begin
                        if (hold_count_reg[i] != 8'd0) begin
                            hold_count_next[i] = hold_count_reg[i] - 8'd1;
                        end
                    end
                    // A pending escape ages only while the serial source is enabled.
                    if (cfg.serial_enable && esc_phase_reg != ESC_PLAIN) begin
                        esc_age_next = age_inc[AGE_W-1:0];
                        if (age_inc > (AGE_W+1)'(ESCAPE_TIMEOUT)) begin
                            esc_phase_next = ESC_PLAIN;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                hold_count_reg[i] <= 8'd0;
            end
            key_down_reg  <= '0;
            key_tap_reg   <= '0;
            quit_reg      <= 1'b0;
            esc_phase_reg <= ESC_PLAIN;
            esc_age_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            hold_count_reg <= hold_count_next;
            key_down_reg   <= key_down_next;
            key_tap_reg    <= key_tap_next;
            quit_reg       <= quit_next;
            esc_phase_reg  <= esc_phase_next;
            esc_age_reg    <= esc_age_next;
            if (item_take && is_tick) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && is_tick) begin
            m_data_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_data_reg};

endmodule

// File: hdl/key_and_serial_to_gamepad_merger.sv
// A tick passes the input register, then the result register, which drives m_axis_tvalid.
// Throughput: one transaction per cycle, but a byte or key event waits only behind a stalled tick.
// A tick stalls only while the result register is full and m_axis_tready is low.
// Reset (aresetn low, synchronous) clears all buttons, latches and the escape decoder,
// holds s_axis_tready low, and loads hold_len with 8 and both source enables with 1.
module key_and_serial_to_gamepad_merger (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // serial_byte, event_type, key_code, key_value, zeros
    input  logic [1:0]  s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // btn_a, btn_b, btn_select, btn_start, btn_up,
                                       // btn_down, btn_left, btn_right, quit_request, zeros
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kgm_pkg::*;

    cfg_t       cfg_reg;
    logic       item_valid;
    item_t      item;
    logic       item_take;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_len        <= 8'd8;
            cfg_reg.serial_enable   <= 1'b1;
            cfg_reg.keyboard_enable <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HOLD_LEN:    cfg_reg.hold_len        <= pwdata[7:0];
                REG_SERIAL_EN:   cfg_reg.serial_enable   <= pwdata[0];
                REG_KEYBOARD_EN: cfg_reg.keyboard_enable <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HOLD_LEN:    prdata = {24'd0, cfg_reg.hold_len};
            REG_SERIAL_EN:   prdata = {31'd0, cfg_reg.serial_enable};
            REG_KEYBOARD_EN: prdata = {31'd0, cfg_reg.keyboard_enable};
            default:         prdata = 32'd0;
        endcase
    end

    kgm_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    kgm_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
